// ----- hdl/dogx_pkg.sv -----
package dogx_pkg;

    // Default sizes, handed to the top level parameters
    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_MAX_HEIGHT  = 1024;
    localparam int DEF_SAMPLE_BITS = 16;

    // Configuration port and register fields
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int ER_W       = 5;
    localparam int SIZE_W     = 11;
    localparam int POS_W      = 10;

    localparam logic [ER_W-1:0]   RST_EDGE_RATIO   = 5'd10;
    localparam logic [SIZE_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [SIZE_W-1:0] RST_IMAGE_HEIGHT = 11'd480;

    // Smallest frame side the position counters accept
    localparam int MIN_SIDE = 3;

    // Entries of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EDGE_RATIO   = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [ER_W-1:0]   edge_ratio;
        logic [SIZE_W-1:0] image_width;
        logic [SIZE_W-1:0] image_height;
    } cfg_t;

    // Position of a window centre, zero when outside the interior
    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } meta_t;

    typedef enum logic [1:0] {
        FE_CLEAR,
        FE_IDLE,
        FE_WRITE
    } front_state_t;

endpackage

// ----- hdl/dogx_if.sv -----
interface dogx_pix_if
    import dogx_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] dog_below;
    logic signed [SAMPLE_BITS-1:0] dog_mid;
    logic signed [SAMPLE_BITS-1:0] dog_above;
    logic        [SAMPLE_BITS-1:0] gauss_sample;
    logic                          frame_start;

    modport source (
        output valid, dog_below, dog_mid, dog_above, gauss_sample, frame_start,
        input  ready
    );
    modport sink (
        input  valid, dog_below, dog_mid, dog_above, gauss_sample, frame_start,
        output ready
    );
endinterface

interface dogx_res_if
    import dogx_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             center_valid;
    logic             is_keypoint;
    logic [POS_W-1:0] center_row;
    logic [POS_W-1:0] center_col;

    modport source (
        output valid, center_valid, is_keypoint, center_row, center_col,
        input  ready
    );
    modport sink (
        input  valid, center_valid, is_keypoint, center_row, center_col,
        output ready
    );
endinterface

interface dogx_cfg_if
    import dogx_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ----- hdl/dogx_ram.sv -----
module dogx_ram
#(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one word, read one word into the output register
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/dogx_front.sv -----
module dogx_front
    import dogx_pkg::*;
#(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    dogx_pix_if.sink            pix_in,
    output logic                push_valid,
    input  logic                push_ready,
    output logic [12*SAMPLE_BITS+$bits(meta_t)-1:0] push_data
);

    localparam int SB    = SAMPLE_BITS;
    localparam int PIX_W = 4 * SB;
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int SWW   = (AW + 1 > SIZE_W) ? AW + 1 : SIZE_W;
    localparam int SHW   = (RW + 1 > SIZE_W) ? RW + 1 : SIZE_W;

    front_state_t     state_reg, state_next;
    logic [AW-1:0]    col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [AW-1:0]    clr_addr_reg;
    logic [AW-1:0]    addr_reg;
    logic [PIX_W-1:0] pix_reg;
    meta_t            meta_reg;

    logic [SWW-1:0]   img_w, w_eff, col_inc;
    logic [SHW-1:0]   img_h, h_eff, row_inc;
    logic [AW-1:0]    cur_col;
    logic [RW-1:0]    cur_row;
    logic [15:0]      row_ext, col_ext;
    logic [PIX_W-1:0] new_pix;
    meta_t            new_meta;
    logic             accept;

    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr;
    logic [PIX_W-1:0] upper_wdata, lower_wdata, upper_rdata, lower_rdata;

    // Clamp the frame size to what the counters and line stores hold
    assign img_w = SWW'(cfg.image_width);
    assign img_h = SHW'(cfg.image_height);
    assign w_eff = (img_w < SWW'(MIN_SIDE)) ? SWW'(MIN_SIDE) :
                   (img_w > SWW'(MAX_WIDTH)) ? SWW'(MAX_WIDTH) : img_w;
    assign h_eff = (img_h < SHW'(MIN_SIDE)) ? SHW'(MIN_SIDE) :
                   (img_h > SHW'(MAX_HEIGHT)) ? SHW'(MAX_HEIGHT) : img_h;

    // Position of the incoming pixel
    assign cur_col = pix_in.frame_start ? '0 : col_reg;
    assign cur_row = pix_in.frame_start ? '0 : row_reg;
    assign col_inc = SWW'(cur_col) + SWW'(1);
    assign row_inc = SHW'(cur_row) + SHW'(1);

    // Window centre sits one row up and one column left
    assign row_ext = 16'(cur_row - RW'(1));
    assign col_ext = 16'(cur_col - AW'(1));
    assign new_meta.valid = (cur_row >= RW'(2)) && (cur_col >= AW'(2));
    assign new_meta.row   = new_meta.valid ? row_ext[POS_W-1:0] : '0;
    assign new_meta.col   = new_meta.valid ? col_ext[POS_W-1:0] : '0;

    assign new_pix = {pix_in.dog_below, pix_in.dog_mid, pix_in.dog_above, pix_in.gauss_sample};
    assign accept  = pix_in.valid && pix_in.ready;

    // Sequence clearing, line store read and write-back
    always_comb
    begin
        state_next    = state_reg;
        pix_in.ready  = 1'b0;
        push_valid    = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_waddr     = addr_reg;
        upper_wdata   = lower_rdata;
        lower_wdata   = pix_reg;
        unique case (state_reg)
            FE_CLEAR:
            begin
                ram_we      = 1'b1;
                ram_waddr   = clr_addr_reg;
                upper_wdata = '0;
                lower_wdata = '0;
                if (clr_addr_reg == AW'(MAX_WIDTH - 1))
                begin
                    state_next = FE_IDLE;
                end
            end
            FE_IDLE:
            begin
                pix_in.ready = 1'b1;
                if (pix_in.valid)
                begin
                    ram_re     = 1'b1;
                    state_next = FE_WRITE;
                end
            end
            FE_WRITE:
            begin
                push_valid = 1'b1;
                if (push_ready)
                begin
                    ram_we     = 1'b1;
                    state_next = FE_IDLE;
                end
            end
            default:
            begin
                state_next = FE_IDLE;
            end
        endcase
    end

    // Advance the position counters
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_inc >= w_eff)
            begin
                col_next = '0;
                row_next = (row_inc >= h_eff) ? '0 : RW'(row_inc);
            end
            else
            begin
                col_next = AW'(col_inc);
                row_next = cur_row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= FE_CLEAR;
            col_reg      <= '0;
            row_reg      <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            if (state_reg == FE_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
        end
    end

    // Hold the request until it is written back
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg <= cur_col;
            pix_reg  <= new_pix;
            meta_reg <= new_meta;
        end
    end

    dogx_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (upper_wdata),
        .re    (ram_re),
        .raddr (cur_col),
        .rdata (upper_rdata)
    );

    dogx_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lower_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (lower_wdata),
        .re    (ram_re),
        .raddr (cur_col),
        .rdata (lower_rdata)
    );

    assign push_data = {meta_reg, upper_rdata, lower_rdata, pix_reg};

endmodule

// ----- hdl/dogx_queue.sv -----
module dogx_queue
#(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Move pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    // Store the request
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hdl/dogx_back.sv -----
module dogx_back
    import dogx_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [ER_W-1:0] edge_ratio,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  logic [12*SAMPLE_BITS+$bits(meta_t)-1:0] pop_data,
    dogx_res_if.source      res_out
);

    localparam int SB    = SAMPLE_BITS;
    localparam int PIX_W = 4 * SB;
    localparam int DW    = SB + 4;
    localparam int TW    = DW + 1;
    localparam int PRW   = 2 * DW;
    localparam int DETW  = 2 * DW + 1;
    localparam int T2W   = 2 * TW;
    localparam int TRRW  = T2W + ER_W + 1;
    localparam int RRW   = 2 * (ER_W + 1);
    localparam int CMPW  = DETW + RRW + 1;

    logic             en, pop;
    meta_t            pop_meta;
    logic [PIX_W-1:0] col_pix [3];
    logic [PIX_W-1:0] win_reg [3][3];

    // Stage valids and payload
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, e_valid_reg, out_valid_reg;
    meta_t a_meta_reg, b_meta_reg, c_meta_reg, d_meta_reg, e_meta_reg;
    logic b_ext_reg, c_ext_reg, d_ext_reg, e_ext_reg;
    logic signed [DW-1:0]   b_dxx_reg, b_dyy_reg, b_dxy_reg;
    logic signed [TW-1:0]   b_tr_reg;
    logic signed [PRW-1:0]  c_pxx_reg, c_pxy_reg;
    logic signed [T2W-1:0]  c_tr2_reg;
    logic signed [DETW-1:0] d_det_reg;
    logic signed [TRRW-1:0] d_trr_reg, e_trr_reg;
    logic [RRW-1:0]         d_rr_reg;
    logic signed [CMPW-1:0] e_rhs_reg;
    logic                   e_neg_reg;
    logic                   out_kp_reg;
    meta_t                  out_meta_reg;

    // Stage A working values
    logic signed [SB-1:0] v, smp;
    logic                 want_max, ext_ok;
    logic signed [DW-1:0] gx [3][3];
    logic signed [DW-1:0] dxx, dyy, dxy;
    logic signed [TW-1:0] tr;
    logic [ER_W:0]        r1;
    logic                 is_edge;

    assign en        = !out_valid_reg || res_out.ready;
    assign pop_ready = en;
    assign pop       = pop_valid && en;

    assign pop_meta   = pop_data[12*SB +: $bits(meta_t)];
    assign col_pix[0] = pop_data[8*SB +: PIX_W];
    assign col_pix[1] = pop_data[4*SB +: PIX_W];
    assign col_pix[2] = pop_data[0 +: PIX_W];

    // Extremum over the 26 neighbours across three scales
    assign v        = signed'(win_reg[1][1][2*SB +: SB]);
    assign want_max = !v[SB-1];

    always_comb
    begin
        ext_ok = 1'b1;
        smp    = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    smp = signed'(win_reg[i][j][(3-k)*SB +: SB]);
                    if (!(k == 1 && i == 1 && j == 1))
                    begin
                        if (want_max ? (smp > v) : (smp < v))
                        begin
                            ext_ok = 1'b0;
                        end
                    end
                end
            end
        end
    end

    // Hessian of the Gaussian, scaled by four
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                gx[i][j] = signed'(DW'(win_reg[i][j][SB-1:0]));
            end
        end
    end

    assign dxx = (gx[1][2] + gx[1][0] - (gx[1][1] <<< 1)) <<< 2;
    assign dyy = (gx[2][1] + gx[0][1] - (gx[1][1] <<< 1)) <<< 2;
    assign dxy = gx[2][2] - gx[2][0] - gx[0][2] + gx[0][0];
    assign tr  = TW'(dxx) + TW'(dyy);
    assign r1  = (ER_W + 1)'(edge_ratio) + (ER_W + 1)'(1);

    // Edge when the determinant is negative or the curvature ratio is too large
    assign is_edge = e_neg_reg || (CMPW'(e_trr_reg) > e_rhs_reg);

    // Shift the window and advance the stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else if (en)
        begin
            a_valid_reg   <= pop;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= c_valid_reg;
            e_valid_reg   <= d_valid_reg;
            out_valid_reg <= e_valid_reg;
            if (pop)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[i][0] <= win_reg[i][1];
                    win_reg[i][1] <= win_reg[i][2];
                    win_reg[i][2] <= col_pix[i];
                end
            end
        end
    end

    // Carry the arithmetic down the stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (pop)
            begin
                a_meta_reg <= pop_meta;
            end
            b_meta_reg <= a_meta_reg;
            b_ext_reg  <= ext_ok;
            b_dxx_reg  <= dxx;
            b_dyy_reg  <= dyy;
            b_dxy_reg  <= dxy;
            b_tr_reg   <= tr;

            c_meta_reg <= b_meta_reg;
            c_ext_reg  <= b_ext_reg;
            c_pxx_reg  <= PRW'(b_dxx_reg) * PRW'(b_dyy_reg);
            c_pxy_reg  <= PRW'(b_dxy_reg) * PRW'(b_dxy_reg);
            c_tr2_reg  <= T2W'(b_tr_reg) * T2W'(b_tr_reg);

            d_meta_reg <= c_meta_reg;
            d_ext_reg  <= c_ext_reg;
            d_det_reg  <= DETW'(c_pxx_reg) - DETW'(c_pxy_reg);
            d_trr_reg  <= TRRW'(c_tr2_reg) * signed'(TRRW'(edge_ratio));
            d_rr_reg   <= RRW'(r1) * RRW'(r1);

            e_meta_reg <= d_meta_reg;
            e_ext_reg  <= d_ext_reg;
            e_neg_reg  <= d_det_reg[DETW-1];
            e_trr_reg  <= d_trr_reg;
            e_rhs_reg  <= CMPW'(d_det_reg) * signed'(CMPW'(d_rr_reg));

            out_meta_reg <= e_meta_reg;
            out_kp_reg   <= e_meta_reg.valid && e_ext_reg && !is_edge;
        end
    end

    assign res_out.valid        = out_valid_reg;
    assign res_out.center_valid = out_meta_reg.valid;
    assign res_out.is_keypoint  = out_kp_reg;
    assign res_out.center_row   = out_meta_reg.row;
    assign res_out.center_col   = out_meta_reg.col;

endmodule

// ----- hdl/dog_extremum_edge_detector.sv -----
// DoG extremum detector with Hessian edge rejection.
//
// pix_in takes one pixel per request in raster order: three DoG samples of
// adjacent scales, the Gaussian sample of the middle scale and frame_start,
// which puts the pixel at row 0, column 0. res_out gives one result per
// pixel: centre position, interior flag and keypoint flag for the window
// centre one row up and one column left of that pixel.
// cfg writes edge_ratio (index 0), image_width (1) and image_height (2);
// it is always ready; the user must write it only while the block is idle,
// which the block itself does not enforce. The front end takes a new pixel
// only after the line store read and write-back of the last one. After reset
// both line stores are cleared, one column a cycle, so pix_in stays not
// ready until all MAX_WIDTH columns (1024 by default) are cleared.
// A stalled receiver holds the result register and freezes the back end
// pipeline; the four entry queue and the front end then hold pixels before
// pix_in stalls in turn.
module dog_extremum_edge_detector
    import dogx_pkg::*;
#(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    dogx_pix_if.sink   pix_in,
    dogx_res_if.source res_out,
    dogx_cfg_if.sink   cfg
);

    localparam int ENTRY_W = 12 * SAMPLE_BITS + $bits(meta_t);

    cfg_t               cfg_reg;
    logic               q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
    logic [ENTRY_W-1:0] q_push_data, q_pop_data;

    // Register writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.edge_ratio   <= RST_EDGE_RATIO;
            cfg_reg.image_width  <= RST_IMAGE_WIDTH;
            cfg_reg.image_height <= RST_IMAGE_HEIGHT;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_EDGE_RATIO:   cfg_reg.edge_ratio   <= cfg.data[ER_W-1:0];
                REG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg.data[SIZE_W-1:0];
                REG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg.data[SIZE_W-1:0];
                default:          ;
            endcase
        end
    end

    dogx_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .pix_in     (pix_in),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data)
    );

    dogx_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    dogx_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .edge_ratio (cfg_reg.edge_ratio),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data),
        .res_out    (res_out)
    );

`ifndef SYNTH
    // A keypoint lies in the frame interior
    assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid && res_out.is_keypoint |-> res_out.center_valid)
        else $error("keypoint outside frame interior");

    // Centres outside the interior report position zero
    assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid && !res_out.center_valid |->
            res_out.center_row == '0 && res_out.center_col == '0)
        else $error("nonzero position on border result");

    // Interior centres are never on row or column zero
    assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid && res_out.center_valid |->
            res_out.center_row != '0 && res_out.center_col != '0)
        else $error("interior centre on frame border");
`endif

endmodule

// ----- dv/tb_dog_extremum_edge_detector.sv -----
`timescale 1ns / 1ps

module tb_dog_extremum_edge_detector;
    import dogx_pkg::*;

    typedef struct packed {
        logic signed [15:0] below;
        logic signed [15:0] mid;
        logic signed [15:0] above;
        logic [15:0]        gauss;
        logic               fs;
    } pixel_t;

    typedef struct packed {
        logic       cv;
        logic       kp;
        logic [9:0] row;
        logic [9:0] col;
    } center_t;

    logic clk;
    logic rst_n;

    dogx_pix_if pix ();
    dogx_res_if res ();
    dogx_cfg_if cfg ();

    dog_extremum_edge_detector i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix),
        .res_out (res),
        .cfg     (cfg)
    );

    // predictor state
    pixel_t  upper_line [1024];
    pixel_t  lower_line [1024];
    pixel_t  win [3][3];
    int      next_row;
    int      next_col;
    int      cur_ratio;
    int      cur_width;
    int      cur_height;

    pixel_t  pending_pixels [$];
    center_t expected_centers [$];
    int      fail_count;
    bit      no_idle;
    bit      feed_hold;
    int      pix_gap;
    int      res_gap;

    function automatic bit window_extremum();
        logic signed [15:0] v;
        bit ok;
        v = win[1][1].mid;
        ok = 1;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                if (v >= 0)
                begin
                    if (win[i][j].below > v || win[i][j].above > v) ok = 0;
                    if (!(i == 1 && j == 1) && win[i][j].mid > v) ok = 0;
                end
                else
                begin
                    if (win[i][j].below < v || win[i][j].above < v) ok = 0;
                    if (!(i == 1 && j == 1) && win[i][j].mid < v) ok = 0;
                end
            end
        return ok;
    endfunction

    function automatic bit window_on_edge();
        longint g, dxx, dyy, dxy, tr, det, r;
        g   = win[1][1].gauss;
        dxx = 4 * (longint'(win[1][2].gauss) + win[1][0].gauss - 2 * g);
        dyy = 4 * (longint'(win[2][1].gauss) + win[0][1].gauss - 2 * g);
        dxy = longint'(win[2][2].gauss) - win[2][0].gauss - win[0][2].gauss
            + win[0][0].gauss;
        tr  = dxx + dyy;
        det = dxx * dyy - dxy * dxy;
        r   = cur_ratio;
        if (det < 0) return 1;
        return tr * tr * r > (r + 1) * (r + 1) * det;
    endfunction

    // advance the window by one pixel and queue the centre it yields
    function automatic void predict_center(pixel_t p);
        int w, h, r, c;
        pixel_t column [3];
        center_t e;
        w = cur_width < 3 ? 3 : (cur_width > 1024 ? 1024 : cur_width);
        h = cur_height < 3 ? 3 : (cur_height > 1024 ? 1024 : cur_height);
        if (p.fs)
        begin
            next_row = 0;
            next_col = 0;
        end
        r = next_row;
        c = next_col;
        if (c >= 1024) c = 0;
        column[0] = upper_line[c];
        column[1] = lower_line[c];
        column[2] = p;
        for (int k = 0; k < 3; k++)
        begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
            win[k][2] = column[k];
        end
        upper_line[c] = lower_line[c];
        lower_line[c] = p;
        e = '0;
        if (r >= 2 && c >= 2)
        begin
            e.cv  = 1;
            e.kp  = window_extremum() && !window_on_edge();
            e.row = 10'(r - 1);
            e.col = 10'(c - 1);
        end
        expected_centers.insert(expected_centers.size(), e);
        if (c + 1 >= w)
        begin
            next_col = 0;
            next_row = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            next_col = c + 1;
            next_row = r;
        end
    endfunction

    // clock
    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // pixel driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix.valid <= 0;
            pix_gap   <= 0;
        end
        else
        begin
            if (pix.valid && pix.ready)
                predict_center({pix.dog_below, pix.dog_mid, pix.dog_above,
                                pix.gauss_sample, pix.frame_start});
            if (!pix.valid || pix.ready)
            begin
                if (pix_gap > 0)
                begin
                    pix.valid <= 0;
                    pix_gap   <= pix_gap - 1;
                end
                else if (pending_pixels.size() > 0 && !feed_hold)
                begin
                    pixel_t p;
                    p = pending_pixels.pop_front();
                    pix.valid        <= 1;
                    pix.dog_below    <= p.below;
                    pix.dog_mid      <= p.mid;
                    pix.dog_above    <= p.above;
                    pix.gauss_sample <= p.gauss;
                    pix.frame_start  <= p.fs;
                    if (!no_idle && $urandom_range(0, 7) == 0)
                        pix_gap <= $urandom_range(1, 10);
                end
                else
                    pix.valid <= 0;
            end
        end
    end

    // result monitor and backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res.ready <= 0;
            res_gap   <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                center_t got, e;
                got = {res.center_valid, res.is_keypoint, res.center_row,
                       res.center_col};
                if (expected_centers.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected center %h", got);
                end
                else
                begin
                    e = expected_centers.pop_front();
                    if (got != e)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("center mismatch: exp v%0d k%0d r%0d c%0d got v%0d k%0d r%0d c%0d",
                                e.cv, e.kp, e.row, e.col, got.cv, got.kp, got.row, got.col);
                    end
                end
            end
            if (res_gap > 0)
            begin
                res.ready <= 0;
                res_gap   <= res_gap - 1;
            end
            else
            begin
                res.ready <= 1;
                if (!no_idle && $urandom_range(0, 7) == 0)
                    res_gap <= $urandom_range(1, 10);
            end
        end
    end

    task automatic write_reg(cfg_reg_t idx, int value);
        @(posedge clk);
        cfg.valid <= 1;
        cfg.index <= idx;
        cfg.data  <= 11'(value);
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 0;
        case (idx)
            REG_EDGE_RATIO:   cur_ratio  = value & 31;
            REG_IMAGE_WIDTH:  cur_width  = value & 2047;
            REG_IMAGE_HEIGHT: cur_height = value & 2047;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_pixels.size() > 0 || pix.valid || expected_centers.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic pixel_t rand_pixel(bit fs);
        pixel_t p;
        p.below = 16'($urandom);
        p.mid   = 16'($urandom);
        p.above = 16'($urandom);
        p.gauss = 16'($urandom);
        // push some centres toward extrema so keypoints appear
        if ($urandom_range(0, 3) == 0) p.mid = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        p.fs = fs;
        return p;
    endfunction

    // queue one frame of w x h pixels with the given sample pattern
    task automatic add_frame(int w, int h, int mode);
        pixel_t p;
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
            begin
                p = rand_pixel(r == 0 && c == 0);
                if (mode == 1)
                begin
                    // flat field: every centre is a tie-extremum
                    p.below = 0; p.mid = 0; p.above = 0; p.gauss = 16'h1000;
                end
                else if (mode == 2)
                begin
                    // smooth blob: keypoint candidates away from edges
                    p.below = -16'sd100; p.above = -16'sd100;
                    p.mid = (r == h / 2 && c == w / 2) ? 16'sd500 : -16'sd50;
                    p.gauss = (r == h / 2 && c == w / 2) ? 16'hffff : 16'h0;
                end
                pending_pixels.insert(pending_pixels.size(), p);
            end
    endtask

    initial
    begin
        int w, h;
        pix.valid = 0; pix.dog_below = 0; pix.dog_mid = 0; pix.dog_above = 0;
        pix.gauss_sample = 0; pix.frame_start = 0;
        res.ready = 0;
        cfg.valid = 0; cfg.index = REG_EDGE_RATIO; cfg.data = 0;
        foreach (upper_line[i]) begin upper_line[i] = '0; lower_line[i] = '0; end
        win = '{default: '0};
        next_row = 0; next_col = 0;
        cur_ratio = RST_EDGE_RATIO; cur_width = RST_IMAGE_WIDTH;
        cur_height = RST_IMAGE_HEIGHT;
        fail_count = 0; no_idle = 0; feed_hold = 0;
        rst_n = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;

        // directed: minimum frame, flat, blob, ratio extremes
        write_reg(REG_IMAGE_WIDTH, 3);
        write_reg(REG_IMAGE_HEIGHT, 3);
        write_reg(REG_EDGE_RATIO, 0);
        add_frame(3, 3, 1);
        drain();
        write_reg(REG_IMAGE_WIDTH, 5);
        write_reg(REG_EDGE_RATIO, 31);
        add_frame(5, 3, 2);
        drain();
        // out of range sizes clamp: width 0 to 3, height 2047 to 1024
        write_reg(REG_IMAGE_WIDTH, 0);
        write_reg(REG_IMAGE_HEIGHT, 2047);
        write_reg(REG_EDGE_RATIO, 1);
        for (int i = 0; i < 8; i++)
            pending_pixels.insert(pending_pixels.size(), rand_pixel(i == 0));
        drain();

        // random frames across settings
        for (int f = 0; f < 16; f++)
        begin
            w = $urandom_range(3, 9);
            h = $urandom_range(3, 7);
            // an oversized width clamps, a wide line wraps past the small sizes
            if (f == 5) w = 2047;
            if (f == 6) w = 100;
            write_reg(REG_IMAGE_WIDTH, w);
            write_reg(REG_IMAGE_HEIGHT, (f == 5 || f == 6) ? 3 : h);
            write_reg(REG_EDGE_RATIO, $urandom_range(0, 31));
            if (f == 5)
            begin
                w = 300;
                h = 1;
            end
            if (f == 6) h = 3;
            add_frame(w, h, $urandom_range(0, 4) == 0 ? 2 : 0);
            // broken frames: stray frame starts and truncation
            if ($urandom_range(0, 3) == 0)
                for (int i = 0; i < 6; i++)
                    pending_pixels.insert(pending_pixels.size(),
                                          rand_pixel($urandom_range(0, 1)));
            if (f == 12) no_idle = 1;
            if (f == 8)
            begin
                // let part of the frame in, then hold until every result is back
                repeat (30) @(posedge clk);
                feed_hold = 1;
                while (expected_centers.size() > 0 || pix.valid) @(posedge clk);
                repeat (5) @(posedge clk);
                feed_hold = 0;
            end
            drain();
        end

        drain();
        if (fail_count == 0)
            $display("tb_dog_extremum_edge_detector OK");
        else
            $display("tb_dog_extremum_edge_detector NOT OK");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("tb_dog_extremum_edge_detector NOT OK");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/dogx_pkg.sv
hdl/dogx_if.sv
hdl/dogx_ram.sv
hdl/dogx_front.sv
hdl/dogx_queue.sv
hdl/dogx_back.sv
hdl/dog_extremum_edge_detector.sv
dv/tb_dog_extremum_edge_detector.sv
